[design/ptnp_pkg.sv]
// ----------------------------------------------------------------------------
// ptnp_pkg: shared types, constants and microprogram
// Control word layout, datapath actions, branch conditions and the
// microcode table of the prime test / next prime sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package ptnp_pkg;

  // Candidate width (positive 32-bit values), divisor width and square width
  localparam int NUM_W = 31;
  localparam int DIV_W = 16;
  localparam int SQ_W  = 2 * DIV_W;
  localparam int PC_W  = 4;

  // First odd trial divisor and the only even prime
  localparam logic [DIV_W-1:0] FIRST_DIV = DIV_W'(3);
  localparam logic [NUM_W-1:0] EVEN_PRIME = NUM_W'(2);

  // Operation codes
  localparam logic OPC_TEST = 1'b0;
  localparam logic OPC_NEXT = 1'b1;

  // Datapath actions
  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_TAKE,
    ACT_INIT_D,
    ACT_SQ,
    ACT_DIV_START,
    ACT_D_INC,
    ACT_CLR_P,
    ACT_SET_P_TWO,
    ACT_SET_P_NOT1,
    ACT_M_INC,
    ACT_EMIT
  } act_t;

  // Branch conditions
  typedef enum logic [3:0] {
    C_ALWAYS,
    C_IN_VALID,
    C_BAD,
    C_M_EVEN,
    C_SQ_GT_M,
    C_DIV_DONE,
    C_REM_ZERO,
    C_OP_TEST,
    C_PRIME,
    C_OUT_FREE
  } cond_t;

  // Control word: action, then jump to tgt when the condition equals pol
  typedef struct packed {
    act_t            act;
    cond_t           cond;
    logic            pol;
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  // Status flags from the datapath to the sequencer
  typedef struct packed {
    logic in_valid;
    logic bad;
    logic m_even;
    logic sq_gt_m;
    logic div_done;
    logic rem_zero;
    logic op_test;
    logic prime;
    logic out_free;
  } status_t;

  // Step addresses
  localparam logic [PC_W-1:0] S_WAIT    = PC_W'(0);
  localparam logic [PC_W-1:0] S_CHK     = PC_W'(1);
  localparam logic [PC_W-1:0] S_TEST    = PC_W'(2);
  localparam logic [PC_W-1:0] S_SQ      = PC_W'(3);
  localparam logic [PC_W-1:0] S_CMP     = PC_W'(4);
  localparam logic [PC_W-1:0] S_DSTART  = PC_W'(5);
  localparam logic [PC_W-1:0] S_DWAIT   = PC_W'(6);
  localparam logic [PC_W-1:0] S_REM     = PC_W'(7);
  localparam logic [PC_W-1:0] S_COMP    = PC_W'(8);
  localparam logic [PC_W-1:0] S_EVEN    = PC_W'(9);
  localparam logic [PC_W-1:0] S_ODD_END = PC_W'(10);
  localparam logic [PC_W-1:0] S_VERDICT = PC_W'(11);
  localparam logic [PC_W-1:0] S_SEARCH  = PC_W'(12);
  localparam logic [PC_W-1:0] S_NEXT    = PC_W'(13);
  localparam logic [PC_W-1:0] S_WOUT    = PC_W'(14);
  localparam logic [PC_W-1:0] S_EMIT    = PC_W'(15);

  function automatic ctrl_t cw(act_t a, cond_t c, logic p, logic [PC_W-1:0] t);
    ctrl_t w;
    w.act  = a;
    w.cond = c;
    w.pol  = p;
    w.tgt  = t;
    return w;
  endfunction

  // Microprogram (pol 0 on C_ALWAYS means fall through)
  function automatic ctrl_t ucode(logic [PC_W-1:0] pc);
    ctrl_t w;
    unique case (pc)
      S_WAIT:    w = cw(ACT_TAKE,       C_IN_VALID, 1'b0, S_WAIT);
      S_CHK:     w = cw(ACT_NONE,       C_BAD,      1'b1, S_WOUT);
      S_TEST:    w = cw(ACT_INIT_D,     C_M_EVEN,   1'b1, S_EVEN);
      S_SQ:      w = cw(ACT_SQ,         C_ALWAYS,   1'b0, S_CMP);
      S_CMP:     w = cw(ACT_NONE,       C_SQ_GT_M,  1'b1, S_ODD_END);
      S_DSTART:  w = cw(ACT_DIV_START,  C_ALWAYS,   1'b0, S_DWAIT);
      S_DWAIT:   w = cw(ACT_NONE,       C_DIV_DONE, 1'b0, S_DWAIT);
      S_REM:     w = cw(ACT_D_INC,      C_REM_ZERO, 1'b0, S_SQ);
      S_COMP:    w = cw(ACT_CLR_P,      C_ALWAYS,   1'b1, S_VERDICT);
      S_EVEN:    w = cw(ACT_SET_P_TWO,  C_ALWAYS,   1'b1, S_VERDICT);
      S_ODD_END: w = cw(ACT_SET_P_NOT1, C_ALWAYS,   1'b0, S_VERDICT);
      S_VERDICT: w = cw(ACT_NONE,       C_OP_TEST,  1'b1, S_WOUT);
      S_SEARCH:  w = cw(ACT_NONE,       C_PRIME,    1'b1, S_WOUT);
      S_NEXT:    w = cw(ACT_M_INC,      C_ALWAYS,   1'b1, S_TEST);
      S_WOUT:    w = cw(ACT_NONE,       C_OUT_FREE, 1'b0, S_WOUT);
      S_EMIT:    w = cw(ACT_EMIT,       C_ALWAYS,   1'b1, S_WAIT);
      default:   w = cw(ACT_NONE,       C_ALWAYS,   1'b1, S_WAIT);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

[design/ptnp_if.sv]
// ----------------------------------------------------------------------------
// ptnp_if: channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptnp_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  logic signed [31:0] number;

  modport source (output valid, output opcode, output number, input ready);
  modport sink   (input valid, input opcode, input number, output ready);
endinterface

interface ptnp_out_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic                  is_prime;
  logic [VALUE_BITS-1:0] prime_found;
  logic                  bad_input;

  modport source (output valid, output is_prime, output prime_found, output bad_input,
                  input ready);
  modport sink   (input valid, input is_prime, input prime_found, input bad_input,
                  output ready);
endinterface

`default_nettype wire

[design/ptnp_divu.sv]
// ----------------------------------------------------------------------------
// ptnp_divu: bit-serial remainder unit
// Restoring division, one dividend bit per cycle; gives n mod d.
// ----------------------------------------------------------------------------
`default_nettype none

module ptnp_divu (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire  [ptnp_pkg::NUM_W-1:0]  dividend,
  input  wire  [ptnp_pkg::DIV_W-1:0]  divisor,
  output logic                        busy,
  output logic [ptnp_pkg::DIV_W-1:0]  rem
);

  localparam int CNT_W = $clog2(ptnp_pkg::NUM_W + 1);

  logic [ptnp_pkg::NUM_W-1:0] dvd_r;
  logic [ptnp_pkg::DIV_W-1:0] dsr_r;
  logic [ptnp_pkg::DIV_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r;
  logic [ptnp_pkg::DIV_W:0]   trial, diff;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    trial   = {rem_r, dvd_r[ptnp_pkg::NUM_W-1]};
    diff    = trial - {1'b0, dsr_r};
    rem_nxt = (trial >= {1'b0, dsr_r}) ? diff[ptnp_pkg::DIV_W-1:0]
                                       : trial[ptnp_pkg::DIV_W-1:0];
  end

  // Hold the bit count; control state only
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(ptnp_pkg::NUM_W);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Advance the operands
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (cnt_r != '0) begin
      dvd_r <= {dvd_r[ptnp_pkg::NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy = (cnt_r != '0);
  assign rem  = rem_r;

endmodule

`default_nettype wire

[design/ptnp_seq.sv]
// ----------------------------------------------------------------------------
// ptnp_seq: microcode sequencer
// Step counter over the microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module ptnp_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  ptnp_pkg::status_t   status,
  output ptnp_pkg::ctrl_t     ctrl
);

  logic [ptnp_pkg::PC_W-1:0] pc_r, pc_nxt;
  logic                      cond_val;

  assign ctrl = ptnp_pkg::ucode(pc_r);

  // Select the branch condition
  always_comb begin
    unique case (ctrl.cond)
      ptnp_pkg::C_ALWAYS:   cond_val = 1'b1;
      ptnp_pkg::C_IN_VALID: cond_val = status.in_valid;
      ptnp_pkg::C_BAD:      cond_val = status.bad;
      ptnp_pkg::C_M_EVEN:   cond_val = status.m_even;
      ptnp_pkg::C_SQ_GT_M:  cond_val = status.sq_gt_m;
      ptnp_pkg::C_DIV_DONE: cond_val = status.div_done;
      ptnp_pkg::C_REM_ZERO: cond_val = status.rem_zero;
      ptnp_pkg::C_OP_TEST:  cond_val = status.op_test;
      ptnp_pkg::C_PRIME:    cond_val = status.prime;
      ptnp_pkg::C_OUT_FREE: cond_val = status.out_free;
      default:              cond_val = 1'b0;
    endcase
    pc_nxt = (cond_val == ctrl.pol) ? ctrl.tgt : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= ptnp_pkg::S_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

[design/prime_test_and_next_prime.sv]
// Operation: bad input goes straight to the result; a test divides by each odd trial
//   divisor d from 3 while d*d <= n, and a search repeats the test on each rejected
//   candidate, incremented, until it finds a prime.
// One item at a time, each trial divisor waiting on the serial remainder unit; a result
//   held in the output register does not block the next input.
// Reset: synchronous active-low rst_n returns the sequencer to the wait step.
// ----------------------------------------------------------------------------
// prime_test_and_next_prime: trial-division prime test and next-prime search
// Microcoded sequencer driving a candidate/divisor datapath and a serial
// remainder unit; results leave through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module prime_test_and_next_prime #(
  parameter int VALUE_BITS = 31
) (
  input  wire              clk,
  input  wire              rst_n,
  ptnp_in_if.sink          in_ch,
  ptnp_out_if.source       out_ch
);

  ptnp_pkg::ctrl_t   ctrl;
  ptnp_pkg::status_t status;

  logic                        op_r;
  logic                        bad_r;
  logic                        prime_r;
  logic [ptnp_pkg::NUM_W-1:0]  m_r;
  logic [ptnp_pkg::DIV_W-1:0]  d_r;
  logic [ptnp_pkg::SQ_W-1:0]   sq_r;
  logic                        div_busy;
  logic [ptnp_pkg::DIV_W-1:0]  div_rem;
  logic                        over;
  logic                        in_xfer;
  logic                        out_valid_r;
  logic                        is_prime_r;
  logic [VALUE_BITS-1:0]       found_r;
  logic                        bad_out_r;

  // Candidate too wide for the result field
  if (VALUE_BITS >= ptnp_pkg::NUM_W) begin : g_nolimit
    assign over = 1'b0;
  end else begin : g_limit
    assign over = |m_r[ptnp_pkg::NUM_W-1:VALUE_BITS];
  end

  assign in_ch.ready = (ctrl.act == ptnp_pkg::ACT_TAKE);
  assign in_xfer     = in_ch.valid && in_ch.ready;

  // Status flags for the sequencer
  always_comb begin
    status.in_valid = in_ch.valid;
    status.bad      = bad_r;
    status.m_even   = ~m_r[0];
    status.sq_gt_m  = sq_r > ptnp_pkg::SQ_W'(m_r);
    status.div_done = ~div_busy;
    status.rem_zero = (div_rem == '0);
    status.op_test  = (op_r == ptnp_pkg::OPC_TEST);
    status.prime    = prime_r;
    status.out_free = ~out_valid_r || out_ch.ready;
  end

  ptnp_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  ptnp_divu u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctrl.act == ptnp_pkg::ACT_DIV_START),
    .dividend (m_r),
    .divisor  (d_r),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  // Datapath registers under microcode control
  always_ff @(posedge clk) begin
    unique case (ctrl.act)
      ptnp_pkg::ACT_TAKE: begin
        if (in_xfer) begin
          op_r  <= in_ch.opcode;
          bad_r <= (in_ch.number == '0) || in_ch.number[31];
          m_r   <= in_ch.number[ptnp_pkg::NUM_W-1:0];
        end
      end
      ptnp_pkg::ACT_INIT_D:     d_r     <= ptnp_pkg::FIRST_DIV;
      ptnp_pkg::ACT_SQ:         sq_r    <= ptnp_pkg::SQ_W'(d_r) * ptnp_pkg::SQ_W'(d_r);
      ptnp_pkg::ACT_D_INC:      d_r     <= d_r + ptnp_pkg::DIV_W'(2);
      ptnp_pkg::ACT_CLR_P:      prime_r <= 1'b0;
      ptnp_pkg::ACT_SET_P_TWO:  prime_r <= (m_r == ptnp_pkg::EVEN_PRIME);
      ptnp_pkg::ACT_SET_P_NOT1: prime_r <= (m_r != ptnp_pkg::NUM_W'(1));
      ptnp_pkg::ACT_M_INC:      m_r     <= m_r + 1'b1;
      default: ;
    endcase
  end

  // Output stage: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.act == ptnp_pkg::ACT_EMIT) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.act == ptnp_pkg::ACT_EMIT) begin
      is_prime_r <= ~bad_r && (op_r == ptnp_pkg::OPC_TEST) && prime_r;
      bad_out_r  <= bad_r || ((op_r == ptnp_pkg::OPC_NEXT) && over);
      found_r    <= (~bad_r && (op_r == ptnp_pkg::OPC_NEXT) && ~over)
                    ? VALUE_BITS'(m_r) : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.is_prime    = is_prime_r;
  assign out_ch.prime_found = found_r;
  assign out_ch.bad_input   = bad_out_r;

endmodule

`default_nettype wire
